### rtl/hamming_read_mapper_macros.svh
// ---------------------------------------------------------------------------
// hamming_read_mapper_macros: assertion macros
// Shared checks for the read mapper modules, compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef HAMMING_READ_MAPPER_MACROS_SVH
`define HAMMING_READ_MAPPER_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define HRM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("hrm check failed");
// next-cycle implication
`define HRM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("hrm check failed");
`else
`define HRM_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define HRM_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

### rtl/hrm_pkg.sv
// ---------------------------------------------------------------------------
// hrm_pkg: shared definitions of the read mapper
// Sizes, command codes and the control/status bundles between the
// controller and the datapath.
// ---------------------------------------------------------------------------
package hrm_pkg;

	localparam int REF_LEN  = 65536;
	localparam int READ_MAX = 64;

	localparam int REF_AW   = $clog2(REF_LEN);
	localparam int POS_W    = REF_AW + 1;
	localparam int SUM_W    = REF_AW + 2;
	localparam int READ_AW  = (READ_MAX > 1) ? $clog2(READ_MAX) : 1;
	localparam int CNT_W    = $clog2(READ_MAX + 1);
	localparam int ADDR_W   = 16;
	localparam int MISS_W   = 7;
	localparam int LEN_W    = 17;
	localparam int CFG_DW   = 17;

	localparam logic [1:0] CMD_WRITE    = 2'd0;
	localparam logic [1:0] CMD_APPEND   = 2'd1;
	localparam logic [1:0] CMD_READBACK = 2'd2;

	localparam logic CFG_MAX_MISMATCH = 1'b0;
	localparam logic CFG_REF_LENGTH   = 1'b1;

	localparam logic [MISS_W-1:0] MAX_MISMATCH_RST = MISS_W'(2);
	localparam logic [LEN_W-1:0]  REF_LENGTH_RST   = LEN_W'(65536);

	typedef struct packed {
		logic ref_wr_in;
		logic buf_app;
		logic mem_rd;
		logic rd_in;
		logic k_clear;
		logic k_inc;
		logic m_clear;
		logic m_inc;
		logic miss_clear;
		logic miss_load;
		logic mark_set;
		logic wb_wr;
		logic load_rb;
		logic load_search;
		logic found;
		logic read_clear;
	} hrm_cmd_t;

	typedef struct packed {
		logic out_free;
		logic k_end;
		logic marked;
		logic miss_over;
		logic m_last;
	} hrm_status_t;

endpackage

### rtl/hrm_dpath.sv
// ---------------------------------------------------------------------------
// hrm_dpath: read mapper datapath
// Reference and mark memories, read buffer, scan counters, mismatch
// counter, configuration registers and the result register.
// ---------------------------------------------------------------------------
`include "hamming_read_mapper_macros.svh"

module hrm_dpath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  hrm_pkg::hrm_cmd_t               cmd,
	output hrm_pkg::hrm_status_t            st,
	input  logic [hrm_pkg::ADDR_W-1:0]      in_address,
	input  logic [1:0]                      in_base,
	input  logic                            cfg_we,
	input  logic                            cfg_index,
	input  logic [hrm_pkg::CFG_DW-1:0]      cfg_data,
	input  logic                            out_ready,
	output logic                            out_valid,
	output logic                            out_kind,
	output logic                            out_found,
	output logic [hrm_pkg::ADDR_W-1:0]      out_position,
	output logic [hrm_pkg::MISS_W-1:0]      out_mismatches,
	output logic                            out_overflow,
	output logic [1:0]                      out_stored_base,
	output logic                            out_marked
);

	logic [1:0] ref_mem  [hrm_pkg::REF_LEN];
	logic       mark_mem [hrm_pkg::REF_LEN];
	logic [1:0] buf_mem  [hrm_pkg::READ_MAX];

	logic [hrm_pkg::MISS_W-1:0] max_mm_q;
	logic [hrm_pkg::LEN_W-1:0]  ref_len_q;
	logic [hrm_pkg::CNT_W-1:0]  count_q;
	logic                       ovf_q;
	logic [hrm_pkg::POS_W-1:0]  k_q;
	logic [hrm_pkg::READ_AW-1:0] m_q;
	logic [hrm_pkg::MISS_W-1:0] miss_q;

	logic [1:0] ref_rd_q;
	logic       mark_rd_q;
	logic [1:0] buf_rd_q;

	logic [hrm_pkg::REF_AW-1:0] k_addr;
	logic [hrm_pkg::REF_AW-1:0] cmp_addr;
	logic [hrm_pkg::REF_AW-1:0] in_addr;
	logic [hrm_pkg::POS_W-1:0]  span;
	logic [hrm_pkg::MISS_W-1:0] miss_n;

	assign in_addr  = hrm_pkg::REF_AW'(in_address);
	assign k_addr   = k_q[hrm_pkg::REF_AW-1:0];
	assign cmp_addr = k_addr + hrm_pkg::REF_AW'(m_q);
	assign span     = (ref_len_q > hrm_pkg::LEN_W'(hrm_pkg::REF_LEN))
		? hrm_pkg::POS_W'(hrm_pkg::REF_LEN) : hrm_pkg::POS_W'(ref_len_q);
	assign miss_n   = miss_q + hrm_pkg::MISS_W'(ref_rd_q != buf_rd_q);

	assign st.out_free  = !out_valid || out_ready;
	assign st.k_end     = (hrm_pkg::SUM_W'(k_q) + hrm_pkg::SUM_W'(count_q))
		> hrm_pkg::SUM_W'(span);
	assign st.marked    = mark_rd_q;
	assign st.miss_over = miss_n > max_mm_q;
	assign st.m_last    = (hrm_pkg::CNT_W'(m_q) + hrm_pkg::CNT_W'(1)) == count_q;

	// reference store and start marks, one write and one read port each
	always_ff @(posedge clk) begin
		if (cmd.ref_wr_in) begin
			ref_mem[in_addr]  <= in_base;
			mark_mem[in_addr] <= 1'b0;
		end else begin
			if (cmd.wb_wr) begin
				ref_mem[cmp_addr] <= buf_rd_q;
			end
			if (cmd.mark_set) begin
				mark_mem[k_addr] <= 1'b1;
			end
		end
		if (cmd.mem_rd) begin
			ref_rd_q  <= ref_mem[cmd.rd_in ? in_addr : cmp_addr];
			mark_rd_q <= mark_mem[cmd.rd_in ? in_addr : k_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.buf_app && count_q < hrm_pkg::CNT_W'(hrm_pkg::READ_MAX)) begin
			buf_mem[count_q[hrm_pkg::READ_AW-1:0]] <= in_base;
		end
		if (cmd.mem_rd) begin
			buf_rd_q <= buf_mem[m_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_mm_q  <= hrm_pkg::MAX_MISMATCH_RST;
			ref_len_q <= hrm_pkg::REF_LENGTH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				hrm_pkg::CFG_MAX_MISMATCH: max_mm_q  <= cfg_data[hrm_pkg::MISS_W-1:0];
				hrm_pkg::CFG_REF_LENGTH:   ref_len_q <= cfg_data[hrm_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (cmd.read_clear) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (cmd.buf_app) begin
			if (count_q < hrm_pkg::CNT_W'(hrm_pkg::READ_MAX)) begin
				count_q <= count_q + hrm_pkg::CNT_W'(1);
			end else begin
				ovf_q <= 1'b1;
			end
		end
	end

	// scan position, base index and mismatch count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q    <= '0;
			m_q    <= '0;
			miss_q <= '0;
		end else begin
			if (cmd.k_clear) begin
				k_q <= '0;
			end else if (cmd.k_inc) begin
				k_q <= k_q + hrm_pkg::POS_W'(1);
			end
			if (cmd.m_clear) begin
				m_q <= '0;
			end else if (cmd.m_inc) begin
				m_q <= m_q + hrm_pkg::READ_AW'(1);
			end
			if (cmd.miss_clear) begin
				miss_q <= '0;
			end else if (cmd.miss_load) begin
				miss_q <= miss_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.load_rb || cmd.load_search) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_rb) begin
			out_kind        <= 1'b1;
			out_found       <= 1'b0;
			out_position    <= '0;
			out_mismatches  <= '0;
			out_overflow    <= 1'b0;
			out_stored_base <= ref_rd_q;
			out_marked      <= mark_rd_q;
		end else if (cmd.load_search) begin
			out_kind        <= 1'b0;
			out_found       <= cmd.found;
			out_position    <= cmd.found ? hrm_pkg::ADDR_W'(k_q) : '0;
			out_mismatches  <= cmd.found ? miss_q : '0;
			out_overflow    <= ovf_q;
			out_stored_base <= 2'd0;
			out_marked      <= 1'b0;
		end
	end

	`HRM_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, count_q <= hrm_pkg::CNT_W'(hrm_pkg::READ_MAX))

endmodule

### rtl/hrm_ctrl.sv
// ---------------------------------------------------------------------------
// hrm_ctrl: read mapper controller
// Takes input words, then steps the start-position scan, the base compare
// and the write-back of a matched read.
// ---------------------------------------------------------------------------
`include "hamming_read_mapper_macros.svh"

module hrm_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           in_cmd,
	input  logic                 in_last,
	input  hrm_pkg::hrm_status_t st,
	output hrm_pkg::hrm_cmd_t    cmd
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_RB   = 4'd1;
	localparam logic [3:0] S_MARK = 4'd2;
	localparam logic [3:0] S_MCHK = 4'd3;
	localparam logic [3:0] S_CRD  = 4'd4;
	localparam logic [3:0] S_CEV  = 4'd5;
	localparam logic [3:0] S_WB   = 4'd6;
	localparam logic [3:0] S_WW   = 4'd7;
	localparam logic [3:0] S_DONE = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_n;
	logic       found_q;
	logic       found_n;
	logic       in_fire;

	assign in_ready = state_q == S_IDLE;
	assign in_fire  = in_valid && in_ready;

	always_comb begin
		cmd     = '0;
		state_n = state_q;
		found_n = found_q;
		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					case (in_cmd)
						hrm_pkg::CMD_WRITE: begin
							cmd.ref_wr_in = 1'b1;
						end
						hrm_pkg::CMD_APPEND: begin
							cmd.buf_app = 1'b1;
							if (in_last) begin
								cmd.k_clear = 1'b1;
								state_n     = S_MARK;
							end
						end
						hrm_pkg::CMD_READBACK: begin
							cmd.mem_rd = 1'b1;
							cmd.rd_in  = 1'b1;
							state_n    = S_RB;
						end
						default: ;
					endcase
				end
			end
			S_RB: begin
				if (st.out_free) begin
					cmd.load_rb = 1'b1;
					state_n     = S_IDLE;
				end
			end
			S_MARK: begin
				if (st.k_end) begin
					found_n = 1'b0;
					state_n = S_DONE;
				end else begin
					cmd.mem_rd = 1'b1;
					state_n    = S_MCHK;
				end
			end
			S_MCHK: begin
				if (st.marked) begin
					cmd.k_inc = 1'b1;
					state_n   = S_MARK;
				end else begin
					cmd.m_clear    = 1'b1;
					cmd.miss_clear = 1'b1;
					state_n        = S_CRD;
				end
			end
			S_CRD: begin
				cmd.mem_rd = 1'b1;
				state_n    = S_CEV;
			end
			S_CEV: begin
				cmd.miss_load = 1'b1;
				if (st.miss_over) begin
					cmd.k_inc = 1'b1;
					state_n   = S_MARK;
				end else if (st.m_last) begin
					cmd.mark_set = 1'b1;
					cmd.m_clear  = 1'b1;
					state_n      = S_WB;
				end else begin
					cmd.m_inc = 1'b1;
					state_n   = S_CRD;
				end
			end
			S_WB: begin
				cmd.mem_rd = 1'b1;
				state_n    = S_WW;
			end
			S_WW: begin
				cmd.wb_wr = 1'b1;
				if (st.m_last) begin
					found_n = 1'b1;
					state_n = S_DONE;
				end else begin
					cmd.m_inc = 1'b1;
					state_n   = S_WB;
				end
			end
			S_DONE: begin
				if (st.out_free) begin
					cmd.load_search = 1'b1;
					cmd.found       = found_q;
					cmd.read_clear  = 1'b1;
					state_n         = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			found_q <= 1'b0;
		end else begin
			state_q <= state_n;
			found_q <= found_n;
		end
	end

	`HRM_ASSERT_IMP(a_load_free, clk, arst_n, cmd.load_rb || cmd.load_search, st.out_free)
	`HRM_ASSERT_IMP(a_mark_match, clk, arst_n, cmd.mark_set, !st.miss_over && st.m_last && !st.k_end)
	`HRM_ASSERT_NXT(a_search_start, clk, arst_n, cmd.buf_app && in_last, !in_ready)

endmodule

### rtl/hamming_read_mapper.sv
// ---------------------------------------------------------------------------
// hamming_read_mapper: brute-force Hamming distance read mapper
// Stores a two-bit reference with start marks, collects reads and places
// each read at the first unmarked start within the mismatch limit.
// ---------------------------------------------------------------------------
// reference writes and non-closing read bases: one word per cycle while idle
// read-back: the stored base and mark are read into registers, then the result
//   word is loaded once the output is free; input is ready again from then on
// search: for each start position the mark is read and checked, then each read
//   base is read and compared, and a matched read is written back base by base
//   before the result is loaded; paced by the single reference read port
// reset clears control, counters and config to defaults; memories are not
//   cleared, so no clearing pass is needed

module hamming_read_mapper (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // address[15:0], base[17:16], zero[23:18]
	input  logic [1:0]  s_tuser,   // cmd[1:0]
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // found[0], position[16:1], mismatches[23:17],
	                               // overflow[24], stored_base[26:25], marked[27], zero[31:28]
	output logic        m_tuser,   // kind[0]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [16:0] cfg_data
);

	hrm_pkg::hrm_cmd_t    cmd;
	hrm_pkg::hrm_status_t st;

	logic                         out_found;
	logic [hrm_pkg::ADDR_W-1:0]   out_position;
	logic [hrm_pkg::MISS_W-1:0]   out_mismatches;
	logic                         out_overflow;
	logic [1:0]                   out_stored_base;
	logic                         out_marked;

	assign cfg_ready = 1'b1;

	hrm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_cmd   (s_tuser),
		.in_last  (s_tlast),
		.st       (st),
		.cmd      (cmd)
	);

	hrm_dpath u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.st              (st),
		.in_address      (s_tdata[15:0]),
		.in_base         (s_tdata[17:16]),
		.cfg_we          (cfg_valid && cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.out_ready       (m_tready),
		.out_valid       (m_tvalid),
		.out_kind        (m_tuser),
		.out_found       (out_found),
		.out_position    (out_position),
		.out_mismatches  (out_mismatches),
		.out_overflow    (out_overflow),
		.out_stored_base (out_stored_base),
		.out_marked      (out_marked)
	);

	assign m_tdata = {4'b0000, out_marked, out_stored_base, out_overflow,
		out_mismatches, out_position, out_found};

endmodule
